FILE: rtl/assert_macros.svh
// assertion macros for the checker module
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property that holds at every clock edge outside reset
`define QPH_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`endif

FILE: rtl/qph_pkg.sv
// package for the quadratic probe hash table: widths, codes, queue entry type
// no dependencies
`timescale 1ns / 1ps
package qph_pkg;
  localparam int unsigned TableDepth = 1024;
  localparam int unsigned SlotBits   = $clog2(TableDepth);
  localparam int unsigned CountBits  = SlotBits + 1;
  localparam int unsigned KeyBits    = 32;
  localparam int unsigned ValueBits  = 32;
  localparam int unsigned HashBits   = 32;
  localparam int unsigned SizeBits   = 10;
  localparam int unsigned StatusBits = 2;
  localparam logic [SizeBits-1:0] SizeReset = SizeBits'(1021);

  typedef enum logic [StatusBits-1:0] {
    ST_INSERTED  = 2'd0,
    ST_REMOVED   = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_REMOVE = 1'b1
  } req_e;

  // classified request handed from front to back
  typedef struct packed {
    logic                  is_remove;
    logic [SlotBits:0]     n;
    logic [SlotBits:0]     base;
    logic [KeyBits-1:0]    key;
    logic [ValueBits-1:0]  value;
  } job_t;

  typedef enum logic [2:0] {
    FS_IDLE,
    FS_REDUCE,
    FS_PUSH
  } front_state_e;

  typedef enum logic [2:0] {
    BS_CLEAR,
    BS_IDLE,
    BS_READ,
    BS_CHECK,
    BS_OUT
  } back_state_e;
endpackage

FILE: rtl/qph_req_if.sv
// request and result channel interfaces
// depends on qph_pkg
`timescale 1ns / 1ps
interface qph_req_if;
  import qph_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 req_type;
  logic [HashBits-1:0]  key_hash;
  logic [KeyBits-1:0]   key;
  logic [ValueBits-1:0] value;
  modport source (output valid, req_type, key_hash, key, value, input ready);
  modport sink   (input valid, req_type, key_hash, key, value, output ready);
endinterface

interface qph_rsp_if;
  import qph_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [StatusBits-1:0] status;
  logic [SlotBits-1:0]   slot;
  logic [CountBits-1:0]  entries_held;
  modport source (output valid, status, slot, entries_held, input ready);
  modport sink   (input valid, status, slot, entries_held, output ready);
endinterface

FILE: rtl/quadratic_probe_hash_table_top.sv
// top level of the quadratic probe hash table
// depends on qph_pkg, qph_req_if, qph_front, qph_queue, qph_back
//
// req channel: req_type (0 insert, 1 remove), key_hash, key, value.
// rsp channel: status, slot, entries_held; one transaction per request.
// cfg: table_size written with cfg_we_i while idle; 0 acts as 1; 10 bits wide, so at most 1023.
// the front reduces the hash modulo size one bit a cycle, the queue holds the job,
// and the back end does a registered memory read then a check per probe,
// worst case (size+1)/2 probes.
// the front reduces the next hash while the back walks probes, so for a stream of
// requests the slower of the two sets the pace.
// after reset the back end clears all 1024 slot states, one slot a cycle;
// requests queue up in the front meanwhile.
// when rsp.ready is low the result holds and the back end stops; the front
// and the two-entry queue keep taking requests until full.
`timescale 1ns / 1ps
module quadratic_probe_hash_table_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [qph_pkg::SizeBits-1:0] cfg_wdata_i,
  qph_req_if.sink                      req,
  qph_rsp_if.source                    rsp
);
  import qph_pkg::*;

  logic [SizeBits-1:0] size_q;
  logic f_valid, f_ready, q_valid, q_ready;
  job_t f_job, q_job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SizeReset;
    end else if (cfg_we_i) begin
      size_q <= cfg_wdata_i;
    end
  end

  qph_front u_front (
    .clk_i, .rst_ni, .size_i(size_q), .req,
    .job_valid_o(f_valid), .job_o(f_job), .job_ready_i(f_ready)
  );

  qph_queue u_queue (
    .clk_i, .rst_ni,
    .in_valid_i(f_valid), .in_job_i(f_job), .in_ready_o(f_ready),
    .out_valid_o(q_valid), .out_job_o(q_job), .out_ready_i(q_ready)
  );

  qph_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i(q_valid), .job_i(q_job), .job_ready_o(q_ready), .rsp
  );
endmodule

FILE: rtl/qph_front.sv
// front end: accepts requests, clamps size, reduces hash modulo size bit-serially
// depends on qph_pkg
`timescale 1ns / 1ps
module qph_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [qph_pkg::SizeBits-1:0] size_i,
  qph_req_if.sink                  req,
  output logic                     job_valid_o,
  output qph_pkg::job_t            job_o,
  input  logic                     job_ready_i
);
  import qph_pkg::*;

  localparam int unsigned CntBits = $clog2(HashBits + 1);

  front_state_e state_q, state_d;
  job_t job_q, job_d;
  logic [HashBits-1:0] hash_q, hash_d;
  logic [CntBits-1:0]  cnt_q, cnt_d;
  logic [SlotBits+1:0] rem_shift;
  logic [SlotBits:0]   n_sel;

  always_comb begin
    if (size_i == '0) begin
      n_sel = (SlotBits+1)'(1);
    end else if ({1'b0, size_i} > (SizeBits+1)'(TableDepth)) begin
      n_sel = (SlotBits+1)'(TableDepth);
    end else begin
      n_sel = (SlotBits+1)'(size_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q  <= job_d;
    hash_q <= hash_d;
    cnt_q  <= cnt_d;
  end

  always_comb begin
    state_d     = state_q;
    job_d       = job_q;
    hash_d      = hash_q;
    cnt_d       = cnt_q;
    req.ready   = 1'b0;
    job_valid_o = 1'b0;
    rem_shift   = {job_q.base, hash_q[HashBits-1]};
    case (state_q)
      FS_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          job_d.is_remove = (req.req_type == REQ_REMOVE);
          job_d.n         = n_sel;
          job_d.base      = '0;
          job_d.key       = req.key;
          job_d.value     = req.value;
          hash_d          = req.key_hash;
          cnt_d           = '0;
          state_d         = FS_REDUCE;
        end
      end
      FS_REDUCE: begin
        // restoring remainder, one hash bit per cycle
        if (rem_shift >= {1'b0, job_q.n}) begin
          job_d.base = (SlotBits+1)'(rem_shift - {1'b0, job_q.n});
        end else begin
          job_d.base = rem_shift[SlotBits:0];
        end
        hash_d = {hash_q[HashBits-2:0], 1'b0};
        cnt_d  = cnt_q + CntBits'(1);
        if (cnt_q == CntBits'(HashBits - 1)) begin
          state_d = FS_PUSH;
        end
      end
      FS_PUSH: begin
        job_valid_o = 1'b1;
        if (job_ready_i) begin
          state_d = FS_IDLE;
        end
      end
      default: state_d = FS_IDLE;
    endcase
  end

  assign job_o = job_q;
endmodule

FILE: rtl/qph_queue.sv
// two-entry queue between front and back ends
// depends on qph_pkg
`timescale 1ns / 1ps
module qph_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  qph_pkg::job_t in_job_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  output qph_pkg::job_t out_job_o,
  input  logic          out_ready_i
);
  import qph_pkg::*;

  job_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] fill_q;
  logic       push, pop;

  assign in_ready_o  = (fill_q != 2'd2);
  assign out_valid_o = (fill_q != 2'd0);
  assign out_job_o   = mem_q[rd_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= 1'b0;
      rd_q   <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop)  rd_q <= ~rd_q;
      fill_q <= fill_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= in_job_i;
    end
  end
endmodule

FILE: rtl/qph_back.sv
// back end: clears slot states, walks the probe sequence over the slot memories
// depends on qph_pkg
`timescale 1ns / 1ps
module qph_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  input  qph_pkg::job_t job_i,
  output logic          job_ready_o,
  qph_rsp_if.source     rsp
);
  import qph_pkg::*;

  logic                 full_mem [TableDepth];
  logic [KeyBits-1:0]   key_mem  [TableDepth];
  logic [ValueBits-1:0] val_mem  [TableDepth];

  back_state_e state_q, state_d;
  job_t        job_q, job_d;
  logic [SlotBits:0]    pos_q, pos_d;     // current probe slot
  logic [SlotBits+1:0]  step_q, step_d;   // 2i+1, added to reach next square
  logic [SlotBits:0]    left_q, left_d;   // probes remaining
  logic [CountBits-1:0] count_q, count_d;
  logic [StatusBits-1:0] status_q, status_d;
  logic [SlotBits-1:0]  slot_q, slot_d;
  logic                 rd_full_q;
  logic [KeyBits-1:0]   rd_key_q;
  logic                 wr_en, wr_full;
  logic                 kv_wr;
  logic [SlotBits-1:0]  wr_addr;
  logic [SlotBits+2:0]  sum;
  logic [SlotBits+1:0]  step_red;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BS_CLEAR;
      pos_q   <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q    <= job_d;
    step_q   <= step_d;
    left_q   <= left_d;
    status_q <= status_d;
    slot_q   <= slot_d;
    rd_full_q <= full_mem[pos_q[SlotBits-1:0]];
    rd_key_q  <= key_mem[pos_q[SlotBits-1:0]];
    if (wr_en) full_mem[wr_addr] <= wr_full;
    if (kv_wr) begin
      key_mem[wr_addr] <= job_q.key;
      val_mem[wr_addr] <= job_q.value;
    end
  end

  always_comb begin
    // step stays below 2n, so one subtract reduces it; pos + step stays below 2n too
    step_red = (step_q >= {1'b0, job_q.n}) ? step_q - {1'b0, job_q.n} : step_q;
    sum      = {2'b0, pos_q} + {1'b0, step_red};
    if (sum >= {2'b0, job_q.n}) sum = sum - {2'b0, job_q.n};
  end

  always_comb begin
    state_d     = state_q;
    job_d       = job_q;
    pos_d       = pos_q;
    step_d      = step_q;
    left_d      = left_q;
    count_d     = count_q;
    status_d    = status_q;
    slot_d      = slot_q;
    wr_en       = 1'b0;
    wr_full     = 1'b0;
    kv_wr       = 1'b0;
    wr_addr     = pos_q[SlotBits-1:0];
    job_ready_o = 1'b0;
    rsp.valid   = 1'b0;
    case (state_q)
      BS_CLEAR: begin
        wr_en = 1'b1;
        pos_d = pos_q + (SlotBits+1)'(1);
        if (pos_q == (SlotBits+1)'(TableDepth - 1)) begin
          pos_d   = '0;
          state_d = BS_IDLE;
        end
      end
      BS_IDLE: begin
        job_ready_o = 1'b1;
        if (job_valid_i) begin
          job_d    = job_i;
          pos_d    = job_i.base;
          step_d   = (SlotBits+2)'(1);
          left_d   = (SlotBits+1)'(({1'b0, job_i.n} + (SlotBits+2)'(1)) >> 1);
          status_d = job_i.is_remove ? ST_NOT_FOUND : ST_FULL;
          slot_d   = '0;
          state_d  = BS_READ;
        end
      end
      BS_READ: state_d = BS_CHECK;
      BS_CHECK: begin
        if (!job_q.is_remove && !rd_full_q) begin
          wr_en    = 1'b1;
          wr_full  = 1'b1;
          kv_wr    = 1'b1;
          count_d  = count_q + CountBits'(1);
          status_d = ST_INSERTED;
          slot_d   = pos_q[SlotBits-1:0];
          state_d  = BS_OUT;
        end else if (job_q.is_remove && rd_full_q && rd_key_q == job_q.key) begin
          wr_en    = 1'b1;
          count_d  = count_q - CountBits'(1);
          status_d = ST_REMOVED;
          slot_d   = pos_q[SlotBits-1:0];
          state_d  = BS_OUT;
        end else if (left_q == (SlotBits+1)'(1)) begin
          state_d = BS_OUT;
        end else begin
          left_d  = left_q - (SlotBits+1)'(1);
          pos_d   = sum[SlotBits:0];
          step_d  = step_red + (SlotBits+2)'(2);
          state_d = BS_READ;
        end
      end
      BS_OUT: begin
        rsp.valid = 1'b1;
        if (rsp.ready) state_d = BS_IDLE;
      end
      default: state_d = BS_IDLE;
    endcase
  end

  assign rsp.status       = status_q;
  assign rsp.slot         = slot_q;
  assign rsp.entries_held = count_q;
endmodule

FILE: rtl/qph_checker.sv
// port-level checker for the quadratic probe hash table, with bind
// depends on qph_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"
module qph_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           rsp_valid_i,
  input logic                           rsp_ready_i,
  input logic [qph_pkg::StatusBits-1:0] rsp_status_i,
  input logic [qph_pkg::SlotBits-1:0]   rsp_slot_i,
  input logic [qph_pkg::CountBits-1:0]  rsp_entries_i
);
  import qph_pkg::*;

  `QPH_ASSERT(a_fail_slot_zero, clk_i, rst_ni, rsp_valid_i && (rsp_status_i == ST_FULL || rsp_status_i == ST_NOT_FOUND) |-> rsp_slot_i == '0, "slot not zero on failure")
  `QPH_ASSERT(a_stall_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_status_i) && $stable(rsp_entries_i), "result changed while stalled")
  `QPH_ASSERT(a_no_back_to_back, clk_i, rst_ni, rsp_valid_i && rsp_ready_i |=> !rsp_valid_i, "result repeated")
endmodule

bind quadratic_probe_hash_table_top qph_checker u_qph_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .rsp_valid_i(rsp.valid), .rsp_ready_i(rsp.ready), .rsp_status_i(rsp.status),
  .rsp_slot_i(rsp.slot), .rsp_entries_i(rsp.entries_held)
);
